>>> design/arpc_pkg.sv
// Package with shared types and codes of the ARP cache resolver.
package arpc_pkg;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NO_ROUTE = 3'd1;
  localparam logic [2:0] ST_REQUEST  = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_NOT_US   = 3'd4;
  localparam logic [2:0] ST_ACCEPTED = 3'd5;

  localparam logic [1:0] SK_NONE    = 2'd0;
  localparam logic [1:0] SK_REQUEST = 2'd1;
  localparam logic [1:0] SK_REPLY   = 2'd2;

  localparam logic [1:0] REG_OWN_IP  = 2'd0;
  localparam logic [1:0] REG_MASK    = 2'd1;
  localparam logic [1:0] REG_GATEWAY = 2'd2;
  localparam logic [1:0] REG_OWN_MAC = 2'd3;

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;

  typedef struct packed {
    logic accept;
    logic check;
    logic rd;
    logic cmp;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic hit;
    logic last;
    logic out_free;
  } stat_t;

endpackage

>>> design/arp_cache_resolver_top.sv
// Top level of the ARP cache resolver.
// One item is in work at a time. An item either ends at the address checks or walks from 1
// to ENTRIES cache slots; each slot costs a registered memory read and a compare. The result
// sits in an output register, so a new item is taken as soon as the previous one has been
// loaded there. The user must see that configuration is written only while the block is idle;
// the block itself does not enforce this. own_mac is kept but not used.
module arp_cache_resolver_top #(
  parameter int ENTRIES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [47:0]  cfg_wdata_i,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic         s_tuser,   // action
  // query_ip, hw_type, proto_type, opcode, sender_mac, sender_ip, target_ip
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [4:0]   m_tuser,   // status, send_kind
  // resolved_mac, send_dest_mac, send_target_ip, send_source_ip
  output logic [159:0] m_tdata
);

  arpc_pkg::cmd_t  cmd;
  arpc_pkg::stat_t stat;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arpc_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tuser_i   (s_tuser),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tuser_o   (m_tuser),
    .m_tdata_o   (m_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

>>> design/arpc_ctrl.sv
// Controller state machine that sequences the check, the cache walk and the result.
module arpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  arpc_pkg::stat_t stat_i,
  output arpc_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_RD    = 5'b00100,
    S_CMP   = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = s_tvalid_i;
        if (s_tvalid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = stat_i.early ? S_FIN : S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d = (stat_i.hit || stat_i.last) ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd_o.fin = stat_i.out_free;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_tready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/arpc_dp.sv
// Datapath with configuration, cache memories, replacement pointer and result register.
module arpc_dp #(
  parameter int ENTRIES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_addr_i,
  input  logic [47:0]     cfg_wdata_i,
  input  logic            s_tuser_i,
  input  logic [191:0]    s_tdata_i,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [4:0]      m_tuser_o,
  output logic [159:0]    m_tdata_o,
  input  arpc_pkg::cmd_t  cmd_i,
  output arpc_pkg::stat_t stat_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [31:0] own_ip_q, mask_q, gw_q;
  logic [47:0] own_mac_q;

  logic        action_q;
  logic [31:0] query_q, sip_q, tip_q;
  logic [15:0] hw_q, pt_q, op_q;
  logic [47:0] smac_q;

  logic [31:0] key_q;
  logic        early_q;
  logic [2:0]  early_code_q;
  logic        hit_q;
  logic [47:0] hit_mac_q;
  logic [IW-1:0] ptr_q, cnt_q;

  logic [31:0] mem_ip [ENTRIES];
  logic [47:0] mem_mac [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic [31:0] rd_ip_q;
  logic [47:0] rd_mac_q;
  logic        rd_vld_q;

  logic        out_vld_q;
  logic [4:0]  out_user_q;
  logic [159:0] out_data_q;

  logic        offsub, bad_frame, early_c, hit_c, last_c;
  logic [31:0] key_c, cur_ip;
  logic [IW-1:0] ptr_dec, ptr_inc, wr_addr;
  logic        ip_we, mac_we, insert, for_us;
  logic [2:0]  res_status;
  logic [1:0]  res_kind;
  logic [47:0] res_rmac, res_dmac;
  logic [31:0] res_tip, res_sip;

  assign offsub    = ((query_q ^ own_ip_q) & mask_q) != 32'd0;
  assign bad_frame = (hw_q != arpc_pkg::HW_ETHERNET) || (pt_q != arpc_pkg::PROTO_IPV4);
  assign early_c   = action_q ? bad_frame : (offsub && (gw_q == 32'd0));
  assign key_c     = action_q ? sip_q : (offsub ? gw_q : query_q);
  assign cur_ip    = rd_vld_q ? rd_ip_q : 32'd0;
  assign hit_c     = (cur_ip == key_q);
  assign last_c    = !hit_c && (cnt_q == LAST_IDX);
  assign ptr_dec   = (ptr_q == '0) ? LAST_IDX : ptr_q - IW'(1);
  assign ptr_inc   = (ptr_q == LAST_IDX) ? '0 : ptr_q + IW'(1);

  assign stat_o.early    = early_c;
  assign stat_o.hit      = hit_c;
  assign stat_o.last     = last_c;
  assign stat_o.out_free = !out_vld_q || m_tready_i;

  // A refreshed slot also gets its address written back, so a cleared slot becomes valid.
  assign for_us  = (tip_q == own_ip_q);
  assign insert  = cmd_i.fin && !early_q && action_q && !hit_q && for_us;
  assign mac_we  = (cmd_i.fin && !early_q && action_q && hit_q) || insert;
  assign ip_we   = mac_we;
  assign wr_addr = hit_q ? ptr_q : ptr_inc;

  always_comb begin
    res_status = arpc_pkg::ST_FOUND;
    res_kind   = arpc_pkg::SK_NONE;
    res_rmac   = '0;
    res_dmac   = '0;
    res_tip    = '0;
    res_sip    = '0;
    if (early_q) begin
      res_status = early_code_q;
    end else if (!action_q) begin
      if (hit_q) begin
        res_rmac = hit_mac_q;
      end else begin
        res_status = arpc_pkg::ST_REQUEST;
        res_kind   = arpc_pkg::SK_REQUEST;
        res_tip    = key_q;
        res_sip    = own_ip_q;
      end
    end else if (!for_us) begin
      res_status = arpc_pkg::ST_NOT_US;
    end else begin
      res_status = arpc_pkg::ST_ACCEPTED;
      if (op_q == arpc_pkg::OP_REQUEST) begin
        res_kind = arpc_pkg::SK_REPLY;
        res_dmac = smac_q;
        res_tip  = sip_q;
        res_sip  = tip_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ip_we) mem_ip[wr_addr] <= sip_q;
    if (mac_we) mem_mac[wr_addr] <= smac_q;
    if (cmd_i.rd) begin
      rd_ip_q  <= mem_ip[ptr_q];
      rd_mac_q <= mem_mac[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= s_tuser_i;
      query_q  <= s_tdata_i[31:0];
      hw_q     <= s_tdata_i[47:32];
      pt_q     <= s_tdata_i[63:48];
      op_q     <= s_tdata_i[79:64];
      smac_q   <= s_tdata_i[127:80];
      sip_q    <= s_tdata_i[159:128];
      tip_q    <= s_tdata_i[191:160];
    end
    if (cmd_i.check) begin
      key_q        <= key_c;
      early_q      <= early_c;
      early_code_q <= action_q ? arpc_pkg::ST_DROPPED : arpc_pkg::ST_NO_ROUTE;
    end
    if (cmd_i.cmp && hit_c) hit_mac_q <= rd_vld_q ? rd_mac_q : 48'd0;
    if (cmd_i.fin) begin
      out_user_q <= {res_kind, res_status};
      out_data_q <= {res_sip, res_tip, res_dmac, res_rmac};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      mask_q    <= '0;
      gw_q      <= '0;
      own_mac_q <= '0;
      vld_q     <= '0;
      ptr_q     <= LAST_IDX;
      cnt_q     <= '0;
      hit_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          arpc_pkg::REG_OWN_IP:  own_ip_q  <= cfg_wdata_i[31:0];
          arpc_pkg::REG_MASK:    mask_q    <= cfg_wdata_i[31:0];
          arpc_pkg::REG_GATEWAY: gw_q      <= cfg_wdata_i[31:0];
          arpc_pkg::REG_OWN_MAC: own_mac_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.check) begin
        cnt_q <= '0;
        hit_q <= 1'b0;
      end
      if (cmd_i.rd) rd_vld_q <= vld_q[ptr_q];
      if (cmd_i.cmp) begin
        if (hit_c) begin
          hit_q <= 1'b1;
        end else begin
          ptr_q <= ptr_dec;
          cnt_q <= cnt_q + IW'(1);
        end
      end
      if (insert) begin
        ptr_q <= ptr_inc;
      end
      if (mac_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.fin) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = out_user_q;
  assign m_tdata_o  = out_data_q;

endmodule

>>> design/arpc_checker.sv
// Port checker of the ARP cache resolver and its bind to the top level.
module arpc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [4:0]   m_tuser,
  input logic [159:0] m_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result transfer changed.");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser[2:0] == arpc_pkg::ST_FOUND) |->
      (m_tuser[4:3] == arpc_pkg::SK_NONE) && (m_tdata[159:48] == '0))
    else $error("Cache hit result carries a send.");

  a_rmac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser[2:0] != arpc_pkg::ST_FOUND) |-> (m_tdata[47:0] == '0))
    else $error("Resolved MAC set without a hit.");

  a_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser[4:3] == arpc_pkg::SK_REPLY) |->
      (m_tuser[2:0] == arpc_pkg::ST_ACCEPTED))
    else $error("Reply sent for a frame that was not accepted.");

endmodule

bind arp_cache_resolver_top arpc_checker u_arpc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

>>> bench/tb_top.sv
// Self-checking testbench of the ARP cache resolver with a cache predictor and a stream scoreboard.
module tb_top;

  localparam int NENT = 8;

  typedef struct packed {
    logic        action;
    logic [31:0] query_ip;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } arp_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] resolved_mac;
    logic [1:0]  send_kind;
    logic [47:0] send_dest_mac;
    logic [31:0] send_target_ip;
    logic [31:0] send_source_ip;
  } arp_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [47:0]  cfg_wdata_i = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic         s_tuser = 1'b0;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [4:0]   m_tuser;
  logic [159:0] m_tdata;

  arp_cache_resolver_top #(.ENTRIES(NENT)) u_dut (.*);

  always #6 clk_i = ~clk_i;

  logic [31:0] mdl_own_ip, mdl_mask, mdl_gw;
  logic [47:0] mdl_own_mac;
  logic [31:0] mdl_ip [NENT];
  logic [47:0] mdl_mac [NENT];
  int unsigned mdl_ptr;

  arp_result_t expected_q[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          quiet_stretch = 1'b0;
  bit          hold_sink = 1'b0;
  bit          stim_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    error_count++;
  endtask

  function automatic bit walk_cache(input logic [31:0] ip);
    for (int n = 0; n < NENT; n++) begin
      if (mdl_ip[mdl_ptr] == ip) return 1'b1;
      mdl_ptr = (mdl_ptr == 0) ? NENT - 1 : mdl_ptr - 1;
    end
    return 1'b0;
  endfunction

  function automatic arp_result_t resolve_item(input arp_item_t it);
    arp_result_t r;
    logic [31:0] q;
    bit cached;
    r = '0;
    if (!it.action) begin
      q = it.query_ip;
      if (((q ^ mdl_own_ip) & mdl_mask) != 0) begin
        if (mdl_gw == 0) begin
          r.status = arpc_pkg::ST_NO_ROUTE;
          return r;
        end
        q = mdl_gw;
      end
      if (walk_cache(q)) begin
        r.status = arpc_pkg::ST_FOUND;
        r.resolved_mac = mdl_mac[mdl_ptr];
      end else begin
        r.status = arpc_pkg::ST_REQUEST;
        r.send_kind = arpc_pkg::SK_REQUEST;
        r.send_target_ip = q;
        r.send_source_ip = mdl_own_ip;
      end
    end else begin
      if (it.hw_type != arpc_pkg::HW_ETHERNET || it.proto_type != arpc_pkg::PROTO_IPV4) begin
        r.status = arpc_pkg::ST_DROPPED;
        return r;
      end
      cached = walk_cache(it.sender_ip);
      if (cached) mdl_mac[mdl_ptr] = it.sender_mac;
      if (it.target_ip != mdl_own_ip) begin
        r.status = arpc_pkg::ST_NOT_US;
        return r;
      end
      if (!cached) begin
        mdl_ptr = (mdl_ptr + 1) % NENT;
        mdl_ip[mdl_ptr] = it.sender_ip;
        mdl_mac[mdl_ptr] = it.sender_mac;
      end
      r.status = arpc_pkg::ST_ACCEPTED;
      if (it.opcode == arpc_pkg::OP_REQUEST) begin
        r.send_kind = arpc_pkg::SK_REPLY;
        r.send_dest_mac = it.sender_mac;
        r.send_target_ip = it.sender_ip;
        r.send_source_ip = it.target_ip;
      end
    end
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      arpc_pkg::REG_OWN_IP:  mdl_own_ip = val[31:0];
      arpc_pkg::REG_MASK:    mdl_mask = val[31:0];
      arpc_pkg::REG_GATEWAY: mdl_gw = val[31:0];
      default:               mdl_own_mac = val;
    endcase
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * NENT + 8) @(posedge clk_i);
  endtask

  // Offers one item and returns after its transfer; a check row is compared too.
  // The valid stays high afterwards; the caller drops it when the stream pauses.
  task automatic send_item(input arp_item_t it, input bit has_fixed, input arp_result_t fixed);
    arp_result_t r;
    if (!quiet_stretch && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while (!quiet_stretch && $urandom_range(99) < 36);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.action;
    s_tdata <= {it.target_ip, it.sender_ip, it.sender_mac, it.opcode, it.proto_type,
                it.hw_type, it.query_ip};
    r = resolve_item(it);
    if (has_fixed && r != fixed) report_mismatch("directed row", r[63:0], fixed[63:0]);
    expected_q.push_back(r);
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic arp_item_t frame(input logic [15:0] op, input logic [47:0] smac,
                                      input logic [31:0] sip, input logic [31:0] tip);
    arp_item_t it;
    it = '0;
    it.action = 1'b1;
    it.hw_type = arpc_pkg::HW_ETHERNET;
    it.proto_type = arpc_pkg::PROTO_IPV4;
    it.opcode = op;
    it.sender_mac = smac;
    it.sender_ip = sip;
    it.target_ip = tip;
    return it;
  endfunction

  function automatic arp_item_t query(input logic [31:0] ip);
    arp_item_t it;
    it = '0;
    it.query_ip = ip;
    return it;
  endfunction

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(5))
      0: return {$urandom} ^ 32'hFFFFFFFF;
      1: return mdl_own_ip;
      2: return (mdl_own_ip & mdl_mask) | ($urandom_range(15) & ~mdl_mask);
      3: return mdl_ip[$urandom_range(NENT - 1)];
      4: return mdl_gw;
      default: return $urandom;
    endcase
  endfunction

  function automatic arp_item_t random_item();
    arp_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(arp_item_t)-1:0];
    if ($urandom_range(99) < 40) begin
      it.action = 1'b0;
      it.query_ip = pick_ip();
    end else begin
      it.action = 1'b1;
      if ($urandom_range(99) < 85) begin
        it.hw_type = arpc_pkg::HW_ETHERNET;
        it.proto_type = arpc_pkg::PROTO_IPV4;
      end else if ($urandom_range(1)) begin
        it.hw_type = arpc_pkg::HW_ETHERNET;
      end
      it.opcode = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 2)) : 16'($urandom);
      it.sender_ip = pick_ip();
      it.target_ip = ($urandom_range(99) < 70) ? mdl_own_ip : pick_ip();
    end
    return it;
  endfunction

  typedef struct {
    arp_item_t   it;
    bit          fixed;
    arp_result_t res;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    arp_result_t none;
    none = '0;
    mdl_own_ip = '0; mdl_mask = '0; mdl_gw = '0; mdl_own_mac = '0;
    foreach (mdl_ip[i]) begin
      mdl_ip[i] = '0;
      mdl_mac[i] = '0;
    end
    mdl_ptr = NENT - 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset every slot holds IP 0 with MAC 0.
    rows.push_back('{query(32'h0), 1'b1,
                    '{arpc_pkg::ST_FOUND, 48'h0, arpc_pkg::SK_NONE, 48'h0, 32'h0, 32'h0}});
    rows.push_back('{query(32'hFFFFFFFF), 1'b1,
                    '{arpc_pkg::ST_REQUEST, 48'h0, arpc_pkg::SK_REQUEST, 48'h0,
                      32'hFFFFFFFF, 32'h0}});
    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].res);
    drain_results();
    rows.delete();

    write_reg(arpc_pkg::REG_OWN_IP, 48'hFFFF_C0A80001);
    write_reg(arpc_pkg::REG_MASK, 48'h0000_FFFFFF00);
    write_reg(arpc_pkg::REG_GATEWAY, 48'h0);
    write_reg(arpc_pkg::REG_OWN_MAC, 48'hFFFFFFFFFFFF);
    rows.push_back('{query(32'h0A000001), 1'b1,
                    '{arpc_pkg::ST_NO_ROUTE, 48'h0, arpc_pkg::SK_NONE, 48'h0, 0, 0}});
    begin
      arp_item_t bad;
      bad = frame(16'h1, 48'h1, 32'hC0A80005, 32'hC0A80001);
      bad.hw_type = 16'hFFFF;
      rows.push_back('{bad, 1'b1,
                      '{arpc_pkg::ST_DROPPED, 48'h0, arpc_pkg::SK_NONE, 48'h0, 0, 0}});
      bad.hw_type = arpc_pkg::HW_ETHERNET;
      bad.proto_type = 16'h0000;
      rows.push_back('{bad, 1'b1,
                      '{arpc_pkg::ST_DROPPED, 48'h0, arpc_pkg::SK_NONE, 48'h0, 0, 0}});
    end
    rows.push_back('{frame(16'h1, 48'hFFFFFFFFFFFF, 32'hC0A80005, 32'hC0A80001), 1'b1,
                    '{arpc_pkg::ST_ACCEPTED, 48'h0, arpc_pkg::SK_REPLY, 48'hFFFFFFFFFFFF,
                      32'hC0A80005, 32'hC0A80001}});
    rows.push_back('{frame(16'h2, 48'h123456789ABC, 32'hC0A80006, 32'hC0A80001), 0, none});
    rows.push_back('{frame(16'hFFFF, 48'h0, 32'hC0A80007, 32'hC0A80001), 0, none});
    rows.push_back('{frame(16'h1, 48'hA5A5A5A5A5A5, 32'hC0A80005, 32'hC0A80099), 0, none});
    rows.push_back('{frame(16'h1, 48'h5A5A, 32'hC0A800EE, 32'hC0A80099), 0, none});
    rows.push_back('{query(32'hC0A80005), 0, none});
    rows.push_back('{query(32'hC0A80006), 0, none});
    rows.push_back('{query(32'hC0A800EE), 0, none});
    for (int k = 0; k < 9; k++)
      rows.push_back('{frame(16'h2, 48'(k * 17 + 3), 32'hC0A80010 + k, 32'hC0A80001), 0, none});
    rows.push_back('{query(32'hC0A80010), 0, none});
    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].res);
    drain_results();

    write_reg(arpc_pkg::REG_GATEWAY, 48'h0000_C0A800FE);
    send_item(query(32'h08080808), 0, none);
    send_item(frame(16'h2, 48'h0000BEEF0000, 32'hC0A800FE, 32'hC0A80001), 0, none);
    send_item(query(32'h08080808), 0, none);

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_reg(arpc_pkg::REG_MASK, 48'hFFFFFFFF);
          write_reg(arpc_pkg::REG_GATEWAY, 48'hFFFFFFFF);
        end
        1: begin
          write_reg(arpc_pkg::REG_OWN_IP, 48'h0);
          write_reg(arpc_pkg::REG_MASK, 48'h0);
          write_reg(arpc_pkg::REG_GATEWAY, 48'h0);
        end
        2: begin
          write_reg(arpc_pkg::REG_OWN_IP, {16'h0, $urandom});
          write_reg(arpc_pkg::REG_MASK, 48'hFFFFFFF0);
          write_reg(arpc_pkg::REG_GATEWAY, {16'h0, $urandom});
          write_reg(arpc_pkg::REG_OWN_MAC, 48'h0);
        end
        default: begin
          write_reg(arpc_pkg::REG_OWN_IP, 48'h0A000001);
          write_reg(arpc_pkg::REG_MASK, 48'hFF000000);
          write_reg(arpc_pkg::REG_GATEWAY, 48'h0);
        end
      endcase
      for (int n = 0; n < 270; n++) begin
        quiet_stretch = (phase == 1 && n >= 60 && n < 160);
        if (phase == 2 && n == 20) hold_sink = 1'b1;
        send_item(random_item(), 0, none);
      end
      quiet_stretch = 1'b0;
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver, with one long hold-off so that the block backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_sink && hold_left == 0) begin
        hold_left = 150;
        hold_sink = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet_stretch || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk_i) begin
    arp_result_t got, exp;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tuser[2:0], m_tdata[47:0], m_tuser[4:3], m_tdata[95:48], m_tdata[127:96],
             m_tdata[159:128]};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got[63:0], 64'h0);
      end else begin
        exp = expected_q.pop_front();
        if (got.status != exp.status) report_mismatch("status", got.status, exp.status);
        if (got.resolved_mac != exp.resolved_mac)
          report_mismatch("resolved_mac", got.resolved_mac, exp.resolved_mac);
        if (got.send_kind != exp.send_kind)
          report_mismatch("send_kind", got.send_kind, exp.send_kind);
        if (got.send_dest_mac != exp.send_dest_mac)
          report_mismatch("send_dest_mac", got.send_dest_mac, exp.send_dest_mac);
        if (got.send_target_ip != exp.send_target_ip)
          report_mismatch("send_target_ip", got.send_target_ip, exp.send_target_ip);
        if (got.send_source_ip != exp.send_source_ip)
          report_mismatch("send_source_ip", got.send_source_ip, exp.send_source_ip);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * NENT + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
